### rtl/mcts_pkg.sv
package mcts_pkg;

    localparam int MAX_CH       = 8;
    localparam int CH_W         = 3;
    localparam int TICK_W       = 16;
    localparam int CHANNELS_DEF = 8;

    localparam logic [TICK_W-1:0] RESET_PERIOD = TICK_W'(20);
    localparam logic [TICK_W-1:0] TICK_MAX     = '1;

    localparam logic MODE_SET     = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;

    typedef logic [MAX_CH-1:0] ch_mask_t;
    typedef logic [TICK_W-1:0] tick_t;

    typedef struct packed {
        logic            wr;
        logic [CH_W-1:0] wr_ch;
        tick_t           wr_period;
        logic            upd;
        tick_t           last;
    } cell_ctl_t;

    typedef struct packed {
        logic     valid;
        tick_t    best;
        ch_mask_t ties;
    } tok_t;

endpackage

### rtl/mcts_req_if.sv
interface mcts_req_if;
    logic                           valid;
    logic                           ready;
    logic                           mode;
    logic [mcts_pkg::CH_W-1:0]      channel;
    logic [mcts_pkg::TICK_W-1:0]    period;

    modport source (output valid, mode, channel, period, input ready);
    modport sink   (input valid, mode, channel, period, output ready);
endinterface

### rtl/mcts_rsp_if.sv
interface mcts_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [mcts_pkg::MAX_CH-1:0]    toggle_mask;
    logic [mcts_pkg::TICK_W-1:0]    interval;
    logic [mcts_pkg::MAX_CH-1:0]    pin_levels;

    modport source (output valid, toggle_mask, interval, pin_levels, input ready);
    modport sink   (input valid, toggle_mask, interval, pin_levels, output ready);
endinterface

### rtl/mcts_cell.sv
module mcts_cell #(
    parameter int INDEX = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mcts_pkg::cell_ctl_t ctl,
    input  mcts_pkg::tok_t      tok_in,
    output mcts_pkg::tok_t      tok_out
);

    localparam mcts_pkg::ch_mask_t BIT = mcts_pkg::ch_mask_t'(1) << INDEX;

    mcts_pkg::tick_t per_reg, per_next;
    mcts_pkg::tick_t cnt_reg, cnt_next;
    mcts_pkg::tok_t  tok_reg, tok_next;

    always_comb
    begin
        per_next = per_reg;
        cnt_next = cnt_reg;
        if (ctl.wr && (ctl.wr_ch == mcts_pkg::CH_W'(INDEX)))
        begin
            per_next = ctl.wr_period;
        end
        if (ctl.upd)
        begin
            cnt_next = (cnt_reg <= ctl.last) ? per_reg : cnt_reg - ctl.last;
        end
    end

    // running minimum and tie set pass one cell per cycle
    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.valid)
        begin
            if (cnt_reg < tok_in.best)
            begin
                tok_next.best = cnt_reg;
                tok_next.ties = BIT;
            end
            else if (cnt_reg == tok_in.best)
            begin
                tok_next.ties = tok_in.ties | BIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            per_reg <= mcts_pkg::RESET_PERIOD;
            cnt_reg <= '0;
            tok_reg <= '0;
        end
        else
        begin
            per_reg <= per_next;
            cnt_reg <= cnt_next;
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

### rtl/multi_channel_toggle_scheduler.sv
// Toggle scheduler for up to eight square-wave channels. A set item (mode 0)
// writes one channel's half-period and gives no result; period 0 disables
// the channel and drives its pin low. An advance item (mode 1) gives one
// result: the countdowns are updated in the accept cycle, then the minimum
// search walks the row of channel cells one cell per cycle, and the result
// passes a finish register and the output register. Request ready is low
// from the accept of an advance until its result enters the output
// register, so no new item is taken while an advance is in flight. One
// result waiting on the output does not hold off the next item; a second
// finished result held behind it keeps request ready low until the output
// is taken.
module multi_channel_toggle_scheduler #(
    parameter int CHANNELS = mcts_pkg::CHANNELS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    mcts_req_if.sink   req,
    mcts_rsp_if.source rsp
);

    mcts_pkg::cell_ctl_t ctl;
    mcts_pkg::tok_t      tok [CHANNELS+1];

    logic               busy_reg, busy_next;
    logic               start_reg;
    mcts_pkg::tick_t    last_reg, last_next;
    mcts_pkg::ch_mask_t pend_reg, pend_next;
    mcts_pkg::ch_mask_t en_reg, en_next;
    mcts_pkg::ch_mask_t pin_reg, pin_next;

    logic               fin_valid_reg, fin_valid_next;
    mcts_pkg::ch_mask_t fin_emit_reg, fin_emit_next;
    mcts_pkg::tick_t    fin_int_reg, fin_int_next;
    mcts_pkg::ch_mask_t fin_pin_reg, fin_pin_next;

    logic               out_valid_reg, out_valid_next;
    mcts_pkg::ch_mask_t out_emit_reg;
    mcts_pkg::tick_t    out_int_reg;
    mcts_pkg::ch_mask_t out_pin_reg;

    logic               acc, ch_ok, move;
    mcts_pkg::ch_mask_t sel_bit, emit;
    mcts_pkg::tok_t     done_tok;

    assign req.ready = !busy_reg;
    assign acc       = req.valid && req.ready;
    assign ch_ok     = int'(req.channel) < CHANNELS;
    assign sel_bit   = mcts_pkg::ch_mask_t'(1) << req.channel;
    assign done_tok  = tok[CHANNELS];
    assign move      = fin_valid_reg && (!out_valid_reg || rsp.ready);
    assign emit      = pend_reg & en_reg;

    always_comb
    begin
        ctl.wr        = acc && (req.mode == mcts_pkg::MODE_SET) && ch_ok
                        && (req.period != '0);
        ctl.wr_ch     = req.channel;
        ctl.wr_period = req.period;
        ctl.upd       = acc && (req.mode == mcts_pkg::MODE_ADVANCE);
        ctl.last      = last_reg;
    end

    assign tok[0] = '{valid: start_reg, best: mcts_pkg::TICK_MAX, ties: '0};

    for (genvar i = 0; i < CHANNELS; i++)
    begin : g_cell
        mcts_cell #(.INDEX(i)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );
    end

    always_comb
    begin
        busy_next      = busy_reg;
        last_next      = last_reg;
        pend_next      = pend_reg;
        en_next        = en_reg;
        pin_next       = pin_reg;
        fin_valid_next = fin_valid_reg;
        fin_emit_next  = fin_emit_reg;
        fin_int_next   = fin_int_reg;
        fin_pin_next   = fin_pin_reg;
        out_valid_next = out_valid_reg;

        if (acc && (req.mode == mcts_pkg::MODE_SET) && ch_ok)
        begin
            if (req.period != '0)
            begin
                en_next = en_reg | sel_bit;
            end
            else
            begin
                en_next  = en_reg & ~sel_bit;
                pin_next = pin_reg & ~sel_bit;
            end
        end
        if (ctl.upd)
        begin
            busy_next = 1'b1;
        end

        if (done_tok.valid)
        begin
            pin_next       = pin_reg ^ emit;
            pend_next      = done_tok.ties;
            last_next      = done_tok.best;
            fin_valid_next = 1'b1;
            fin_emit_next  = emit;
            fin_int_next   = (done_tok.best > mcts_pkg::tick_t'(1))
                             ? done_tok.best - mcts_pkg::tick_t'(1) : done_tok.best;
            fin_pin_next   = pin_reg ^ emit;
        end

        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (move)
        begin
            out_valid_next = 1'b1;
            fin_valid_next = 1'b0;
            busy_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            start_reg     <= 1'b0;
            last_reg      <= '0;
            pend_reg      <= '0;
            en_reg        <= '0;
            pin_reg       <= '0;
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            start_reg     <= ctl.upd;
            last_reg      <= last_next;
            pend_reg      <= pend_next;
            en_reg        <= en_next;
            pin_reg       <= pin_next;
            fin_valid_reg <= fin_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fin_emit_reg <= fin_emit_next;
        fin_int_reg  <= fin_int_next;
        fin_pin_reg  <= fin_pin_next;
        if (move)
        begin
            out_emit_reg <= fin_emit_reg;
            out_int_reg  <= fin_int_reg;
            out_pin_reg  <= fin_pin_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.toggle_mask = out_emit_reg;
    assign rsp.interval    = out_int_reg;
    assign rsp.pin_levels  = out_pin_reg;

endmodule

### rtl/mcts_chk.sv
module mcts_chk (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        in_mode,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [mcts_pkg::MAX_CH-1:0] toggle_mask,
    input logic [mcts_pkg::TICK_W-1:0] interval,
    input logic [mcts_pkg::MAX_CH-1:0] pin_levels
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(toggle_mask) && $stable(interval)
                                    && $stable(pin_levels))
        else $error("stalled result changed");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_mode == mcts_pkg::MODE_ADVANCE) |=> !in_ready)
        else $error("advance item not holding off input");

    a_interval: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> interval != '0)
        else $error("zero interval");

endmodule

bind multi_channel_toggle_scheduler mcts_chk u_mcts_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (req.valid),
    .in_ready    (req.ready),
    .in_mode     (req.mode),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .toggle_mask (rsp.toggle_mask),
    .interval    (rsp.interval),
    .pin_levels  (rsp.pin_levels)
);

### bench/mcts_checker.sv
module mcts_checker
    import mcts_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    mcts_req_if  req,
    mcts_rsp_if  rsp,
    output int   errors,
    output int   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        ch_mask_t toggle_mask;
        tick_t    interval;
        ch_mask_t pin_levels;
    } toggle_event_t;

    localparam ch_mask_t LIVE_CHANNELS = ch_mask_t'((1 << CHANNELS) - 1);

    tick_t         period_tab [MAX_CH];
    tick_t         countdown  [MAX_CH];
    tick_t         last_gap;
    ch_mask_t      tied_set;
    ch_mask_t      enabled;
    ch_mask_t      pins;
    toggle_event_t expected_toggles [$];

    // Advance to the next event: age every countdown, reload expired ones,
    // find the new minimum, then fire the set tied at the previous minimum.
    function automatic toggle_event_t next_toggle();
        tick_t         best;
        ch_mask_t      ties;
        toggle_event_t ev;
        int            i;
        best = TICK_MAX;
        ties = '0;
        for (i = 0; i < CHANNELS; i++)
        begin
            if (countdown[i] <= last_gap)
                countdown[i] = period_tab[i];
            else
                countdown[i] = countdown[i] - last_gap;
            if (countdown[i] < best)
            begin
                best = countdown[i];
                ties = ch_mask_t'(1) << i;
            end
            else if (countdown[i] == best)
            begin
                ties[i] = 1'b1;
            end
        end
        ev.toggle_mask = tied_set & enabled & LIVE_CHANNELS;
        pins           = pins ^ ev.toggle_mask;
        ev.interval    = (best > 1) ? best - 1'b1 : best;
        ev.pin_levels  = pins;
        tied_set       = ties;
        last_gap       = best;
        return ev;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        toggle_event_t exp_ev;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CH; i++)
            begin
                period_tab[i] = RESET_PERIOD;
                countdown[i]  = '0;
            end
            last_gap = '0;
            tied_set = '0;
            enabled  = '0;
            pins     = '0;
            errors   = 0;
            expected_toggles.delete();
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_toggles.size() == 0)
                begin
                    $error("unexpected result: toggle_mask %0h interval %0d pin_levels %0h",
                           rsp.toggle_mask, rsp.interval, rsp.pin_levels);
                    errors++;
                end
                else
                begin
                    exp_ev = expected_toggles.pop_front();
                    if (rsp.toggle_mask !== exp_ev.toggle_mask)
                    begin
                        $error("toggle_mask: expected %0h, actual %0h",
                               exp_ev.toggle_mask, rsp.toggle_mask);
                        errors++;
                    end
                    if (rsp.interval !== exp_ev.interval)
                    begin
                        $error("interval: expected %0d, actual %0d",
                               exp_ev.interval, rsp.interval);
                        errors++;
                    end
                    if (rsp.pin_levels !== exp_ev.pin_levels)
                    begin
                        $error("pin_levels: expected %0h, actual %0h",
                               exp_ev.pin_levels, rsp.pin_levels);
                        errors++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                if (req.mode == MODE_ADVANCE)
                begin
                    expected_toggles.push_back(next_toggle());
                end
                else if (req.channel < CHANNELS)
                begin
                    if (req.period != '0)
                    begin
                        period_tab[req.channel] = req.period;
                        enabled[req.channel]    = 1'b1;
                    end
                    else
                    begin
                        enabled[req.channel] = 1'b0;
                        pins[req.channel]    = 1'b0;
                    end
                end
            end
        end
        outstanding = expected_toggles.size();
    end

endmodule

### bench/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mcts_pkg::*;

    localparam int RX_HOLD_CYCLES = 400;

    logic clk;
    logic rst_n;
    logic tx_idle;
    logic rx_idle;
    logic rx_hold;
    int   errors;
    int   outstanding;

    mcts_req_if req ();
    mcts_rsp_if rsp ();

    multi_channel_toggle_scheduler #(
        .CHANNELS(CHANNELS_DEF)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    mcts_checker #(
        .CHANNELS(CHANNELS_DEF)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    initial
    begin
        #1ms;
        $display("multi_channel_toggle_scheduler test failed");
        $finish;
    end

    // Offer one item and return at the edge that takes it; valid stays high.
    task automatic drive_request(input logic mode, input logic [CH_W-1:0] ch,
                                 input tick_t per);
        while (tx_idle && $urandom_range(99) < 21)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid   <= 1'b1;
        req.mode    <= mode;
        req.channel <= ch;
        req.period  <= per;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    task automatic random_request();
        tick_t per;
        case ($urandom_range(9))
            0:       per = '0;
            1:       per = tick_t'(1);
            2:       per = TICK_MAX;
            3, 4:    per = tick_t'($urandom);
            default: per = tick_t'($urandom_range(40, 1));
        endcase
        if ($urandom_range(99) < 65)
            drive_request(MODE_ADVANCE, CH_W'($urandom), tick_t'($urandom));
        else
            drive_request(MODE_SET, CH_W'($urandom_range(MAX_CH - 1)), per);
    endtask

    task automatic wait_all_results();
        req.valid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int held;
        held      = 0;
        rsp.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold && held == 0)
            begin
                rsp.ready <= 1'b0;
                repeat (RX_HOLD_CYCLES - 1)
                    @(posedge clk);
                held = 1;
            end
            else
            begin
                rsp.ready <= !(rx_idle && $urandom_range(99) < 21);
            end
        end
    end

    initial
    begin
        int guard;
        rst_n       = 1'b0;
        tx_idle     = 1'b1;
        rx_idle     = 1'b1;
        rx_hold     = 1'b0;
        req.valid   = 1'b0;
        req.mode    = MODE_SET;
        req.channel = '0;
        req.period  = '0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first advance straight out of reset, all channels disabled
        drive_request(MODE_ADVANCE, '0, '0);
        // every channel at the top period: all tie at the maximum
        for (int i = 0; i < MAX_CH; i++)
            drive_request(MODE_SET, CH_W'(i), TICK_MAX);
        drive_request(MODE_ADVANCE, '1, '1);
        drive_request(MODE_ADVANCE, '0, 16'hAAAA);
        drive_request(MODE_SET, CH_W'(0), tick_t'(1));
        drive_request(MODE_SET, CH_W'(7), tick_t'(16'hAAAA));
        drive_request(MODE_SET, CH_W'(1), tick_t'(16'h5555));
        drive_request(MODE_SET, CH_W'(3), '0);
        repeat (3)
            drive_request(MODE_ADVANCE, CH_W'($urandom), tick_t'($urandom));
        drive_request(MODE_SET, CH_W'(5), tick_t'(2));
        repeat (3)
            drive_request(MODE_ADVANCE, CH_W'($urandom), tick_t'($urandom));
        // disable a channel whose pin may be high
        drive_request(MODE_SET, CH_W'(0), '0);
        drive_request(MODE_ADVANCE, '0, '0);

        repeat (190)
            random_request();

        // receiver stalls while advances keep coming, then drain
        tx_idle = 1'b0;
        rx_hold <= 1'b1;
        repeat (20)
            drive_request(MODE_ADVANCE, CH_W'($urandom), tick_t'($urandom));
        wait_all_results();

        rx_idle <= 1'b0;
        repeat (140)
            random_request();
        tx_idle = 1'b1;
        rx_idle <= 1'b1;
        repeat (170)
            random_request();

        req.valid <= 1'b0;
        guard = 0;
        while (outstanding != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4 * MAX_CH)
            @(posedge clk);

        if (errors == 0 && outstanding == 0)
            $display("multi_channel_toggle_scheduler test passed");
        else
            $display("multi_channel_toggle_scheduler test failed");
        $finish;
    end

endmodule
